// ===== rtl/core/cters_pkg.sv =====
// Package for the cycle-to-event rate scheduler.
// Holds field widths, rate constants and the item kind codes.
// No dependencies.
package cters_pkg;

	localparam int unsigned LINES_PER_FRAME = 526;
	localparam int unsigned FRAME_RATE      = 30;
	localparam int unsigned SOUND_RATE      = 44100;
	localparam int unsigned TIMER_BASE      = 21000000;

	localparam int unsigned ACC_W   = 32;
	localparam int unsigned FRAC_W  = 24;
	localparam int unsigned FREQ_W  = 27;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned CYC_W   = 8;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned LINE_W  = 10;
	localparam int unsigned LIF_W   = 9;
	localparam int unsigned FLD_W   = 2;
	localparam int unsigned CNT_W   = $clog2(ACC_W);
	localparam int unsigned TQ_W    = $clog2(TIMER_BASE + 1);
	localparam int unsigned CFG_IDX_W = 1;

	localparam int unsigned HALF_LINES = LINES_PER_FRAME / 2;

	localparam logic [ACC_W-1:0]  SOUND_STEP = ACC_W'(SOUND_RATE);
	localparam logic [ACC_W-1:0]  VIDEO_STEP = ACC_W'(LINES_PER_FRAME * FRAME_RATE);
	localparam logic [ACC_W-1:0]  TIMER_DIVIDEND = ACC_W'(TIMER_BASE);
	localparam logic [FREQ_W-1:0] RESET_FREQ = FREQ_W'(12500000);

	localparam logic [CFG_IDX_W-1:0] REG_CPU_FREQ    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMER_DELAY = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH  = 2'd0,
		KIND_VIDEO = 2'd1,
		KIND_SOUND = 2'd2,
		KIND_TIMER = 2'd3
	} kind_t;

endpackage

// ===== rtl/core/cycle_to_event_rate_scheduler.sv =====
// Cycle-to-event rate scheduler: push/poll request handling, bit-serial divider
// and bit-serial product accumulation for the video, sound and timer accumulators.
// Depends on cters_pkg.

// A poll request is taken only when the output register is free; its answer is
// registered there, and the next request may follow straight after. A push
// request holds the block through ST_DIV, ST_HORN, ST_ADD, ST_FIX and ST_OUT:
// the restoring divider gives one quotient bit a cycle, the four products are
// built MSB-first from the registered quotient bits, then finished and added,
// the remainder correction applied and the result handed over once the output
// register is free, after which the next request is taken. Writing timer_delay
// recomputes the timer increment in the same divider, holding off requests. Push
// requests are accepted while an earlier result waits in the output register.
module cycle_to_event_rate_scheduler import cters_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [KIND_W-1:0]    kind,
	input  logic [CYC_W-1:0]     cycles,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 fired,
	output logic [LIF_W-1:0]     line_in_field,
	output logic                 field_index,
	output logic [LINE_W-1:0]    frame_line,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [FREQ_W-1:0]    cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_HORN,
		ST_ADD,
		ST_FIX,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                tdiv_q;
	logic                tq_dirty_q;
	logic                qv_q;
	logic [FREQ_W-1:0]   cpu_freq_q;
	logic [DELAY_W-1:0]  timer_delay_q;
	logic [ACC_W-1:0]    cpu_acc_q, sound_acc_q, video_acc_q, timer_acc_q;
	logic [LINE_W-1:0]   line_q;
	logic [LIF_W-1:0]    lif_q;
	logic [FLD_W-1:0]    fld_q;

	logic [FREQ_W-1:0]   rem_q;
	logic [ACC_W-1:0]    div_sh_q;
	logic                qb_q;
	logic [TQ_W-1:0]     tq_q;
	logic [CYC_W-1:0]    cyc_q;
	logic [ACC_W-1:0]    pf_q, ps_q, pv_q, pt_q;

	kind_t               in_kind;
	logic                in_acc, out_free;
	logic                start_push, start_tdiv;
	logic                poll_acc, out_load, line_step;
	logic [ACC_W-1:0]    sel_acc;
	logic                due, poll_fire;
	logic [LINE_W-1:0]   line_n;
	logic [LIF_W-1:0]    lif_n;
	logic [FLD_W-1:0]    fld_n;
	logic [FREQ_W-1:0]   divisor;
	logic [FREQ_W:0]     rem_sh;
	logic                ge;
	logic [FREQ_W-1:0]   rem_nx;
	logic [ACC_W-1:0]    cpu_sum;
	logic                timer_on;

	assign in_kind  = kind_t'(kind);
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || tq_dirty_q || (!out_free && in_kind != KIND_PUSH);
	assign in_acc   = in_valid && !in_stall;
	assign start_push = in_acc && in_kind == KIND_PUSH;
	assign start_tdiv = state_q == ST_IDLE && tq_dirty_q;
	assign timer_on = timer_delay_q != '0;
	assign poll_acc = in_acc && in_kind != KIND_PUSH;
	assign out_load = poll_acc || (state_q == ST_OUT && out_free);

	always_comb begin
		case (in_kind)
			KIND_VIDEO: sel_acc = video_acc_q;
			KIND_SOUND: sel_acc = sound_acc_q;
			KIND_TIMER: sel_acc = timer_acc_q;
			default:    sel_acc = '0;
		endcase
	end

	assign due       = sel_acc[ACC_W-1:FRAC_W] != '0;
	assign poll_fire = due && in_kind != KIND_PUSH;
	assign line_step = poll_fire && in_kind == KIND_VIDEO;

	// line counter with running field split
	always_comb begin
		if (line_q == LINE_W'(LINES_PER_FRAME - 1)) begin
			line_n = '0;
			lif_n  = '0;
			fld_n  = '0;
		end else begin
			line_n = line_q + 1'b1;
			if (lif_q == LIF_W'(HALF_LINES - 1)) begin
				lif_n = '0;
				fld_n = fld_q + 1'b1;
			end else begin
				lif_n = lif_q + 1'b1;
				fld_n = fld_q;
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	assign divisor = tdiv_q ? FREQ_W'(timer_delay_q) : cpu_freq_q;
	assign rem_sh  = {rem_q, div_sh_q[ACC_W-1]};
	assign ge      = rem_sh >= {1'b0, divisor};
	assign rem_nx  = ge ? FREQ_W'(rem_sh - {1'b0, divisor}) : rem_sh[FREQ_W-1:0];

	assign cpu_sum = cpu_acc_q + ACC_W'(cpu_freq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			tdiv_q        <= 1'b0;
			tq_dirty_q    <= 1'b0;
			qv_q          <= 1'b0;
			cpu_freq_q    <= RESET_FREQ;
			timer_delay_q <= '0;
			cpu_acc_q     <= '0;
			sound_acc_q   <= '0;
			video_acc_q   <= '0;
			timer_acc_q   <= '0;
			line_q        <= '0;
			lif_q         <= '0;
			fld_q         <= '0;
			out_valid     <= 1'b0;
			fired         <= 1'b0;
			line_in_field <= '0;
			field_index   <= 1'b0;
			frame_line    <= '0;
		end else begin
			qv_q <= state_q == ST_DIV && !tdiv_q;
			if (out_load)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start_tdiv) begin
						tdiv_q     <= 1'b1;
						tq_dirty_q <= 1'b0;
						cnt_q      <= '0;
						state_q    <= ST_DIV;
					end else if (start_push) begin
						tdiv_q  <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else if (in_acc) begin
						fired         <= poll_fire;
						line_in_field <= line_step ? lif_n : lif_q;
						field_index   <= line_step ? fld_n[0] : fld_q[0];
						frame_line    <= line_step ? line_n : line_q;
						if (poll_fire) begin
							case (in_kind)
								KIND_VIDEO: begin
									video_acc_q <= video_acc_q - (ACC_W'(1) << FRAC_W);
									line_q      <= line_n;
									lif_q       <= lif_n;
									fld_q       <= fld_n;
								end
								KIND_SOUND: sound_acc_q <= sound_acc_q - (ACC_W'(1) << FRAC_W);
								KIND_TIMER: timer_acc_q <= timer_acc_q - (ACC_W'(1) << FRAC_W);
								default: ;
							endcase
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ACC_W - 1))
						state_q <= tdiv_q ? ST_IDLE : ST_HORN;
				end
				ST_HORN: state_q <= ST_ADD;
				ST_ADD: begin
					cpu_acc_q   <= cpu_acc_q + pf_q;
					sound_acc_q <= sound_acc_q + ps_q;
					video_acc_q <= video_acc_q + pv_q;
					if (timer_on)
						timer_acc_q <= timer_acc_q + pt_q;
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					// remainder drifted: one more step, keep the fraction only
					if (cpu_acc_q[ACC_W-1:FRAC_W] != cyc_q) begin
						cpu_acc_q   <= {{(ACC_W-FRAC_W){1'b0}}, cpu_sum[FRAC_W-1:0]};
						sound_acc_q <= sound_acc_q + SOUND_STEP;
						video_acc_q <= video_acc_q + VIDEO_STEP;
						if (timer_on)
							timer_acc_q <= timer_acc_q + ACC_W'(tq_q);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						fired         <= 1'b0;
						line_in_field <= lif_q;
						field_index   <= fld_q[0];
						frame_line    <= line_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_we) begin
				case (cfg_idx)
					REG_CPU_FREQ: cpu_freq_q <= cfg_wdata;
					REG_TIMER_DELAY: begin
						timer_delay_q <= cfg_wdata[DELAY_W-1:0];
						tq_dirty_q    <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// serial datapath: dividend shift, remainder, quotient bits, MSB-first products
	always_ff @(posedge clk) begin
		if (start_push || start_tdiv) begin
			rem_q    <= '0;
			div_sh_q <= start_tdiv ? TIMER_DIVIDEND : {cycles, {FRAC_W{1'b0}}};
			pf_q     <= '0;
			ps_q     <= '0;
			pv_q     <= '0;
			pt_q     <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q    <= rem_nx;
			div_sh_q <= {div_sh_q[ACC_W-2:0], 1'b0};
		end
		if (state_q == ST_DIV) begin
			qb_q <= ge;
			if (tdiv_q)
				tq_q <= {tq_q[TQ_W-2:0], ge};
		end
		if (start_push)
			cyc_q <= cycles;
		if (qv_q) begin
			pf_q <= {pf_q[ACC_W-2:0], 1'b0} + (qb_q ? ACC_W'(cpu_freq_q) : '0);
			ps_q <= {ps_q[ACC_W-2:0], 1'b0} + (qb_q ? SOUND_STEP : '0);
			pv_q <= {pv_q[ACC_W-2:0], 1'b0} + (qb_q ? VIDEO_STEP : '0);
			pt_q <= {pt_q[ACC_W-2:0], 1'b0} + (qb_q ? ACC_W'(tq_q) : '0);
		end
	end

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_line < LINE_W'(LINES_PER_FRAME))
		else $error("frame line out of range");

	a_field_split: assert property (@(posedge clk) disable iff (!arst_n)
		line_q == LINE_W'(lif_q) + LINE_W'(fld_q) * LINE_W'(HALF_LINES))
		else $error("line split out of step with line counter");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && divisor != '0) |-> rem_q < divisor)
		else $error("divider remainder not below divisor");

	a_poll_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_kind != KIND_PUSH) |=> out_valid)
		else $error("poll request gave no result");

endmodule
